// ===== sv/iurf_pkg.sv =====
// Shared types, constants and helper functions for the IPv6/UDP receive filter.
// No dependencies; imported by every module of the block.
package iurf_pkg;

  localparam int MAX_FRAME_BYTES = 2047;
  localparam int BC_W = $clog2(MAX_FRAME_BYTES + 1);

  // Frame layout offsets (Ethernet header, IPv6 header, UDP header)
  localparam int OFF_ETYPE_HI  = 12;
  localparam int OFF_ETYPE_LO  = 13;
  localparam int OFF_VERSION   = 14;
  localparam int OFF_NEXT_HDR  = 20;
  localparam int OFF_SRC       = 22;
  localparam int OFF_SRC_LO    = 30;
  localparam int OFF_DST       = 38;
  localparam int OFF_SPORT     = 54;
  localparam int OFF_DPORT     = 56;
  localparam int OFF_ULEN      = 58;
  localparam int IP_HDR_END    = 14 + 40;
  localparam int HDR_BYTES     = 14 + 40 + 8;
  localparam int UDP_HDR_BYTES = 8;

  localparam logic [7:0] ETYPE_HI   = 8'h86;
  localparam logic [7:0] ETYPE_LO   = 8'hdd;
  localparam logic [3:0] IP_VER6    = 4'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [47:0] MAC_RST       = 48'h0;
  localparam logic [63:0] GROUP_HI_RST  = 64'hff12_0000_0000_0000;
  localparam logic [63:0] GROUP_LO_RST  = 64'h0000_0000_0000_8080;

  localparam logic [1:0] CFG_LOCAL_MAC = 2'd0;
  localparam logic [1:0] CFG_GROUP_HI  = 2'd1;
  localparam logic [1:0] CFG_GROUP_LO  = 2'd2;

  localparam logic [2:0] VERD_OK       = 3'd0;
  localparam logic [2:0] VERD_SHORT    = 3'd1;
  localparam logic [2:0] VERD_ETYPE    = 3'd2;
  localparam logic [2:0] VERD_VERSION  = 3'd3;
  localparam logic [2:0] VERD_NOT_UDP  = 3'd4;
  localparam logic [2:0] VERD_ADDR     = 3'd5;
  localparam logic [2:0] VERD_LENGTH   = 3'd6;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Output queue; depth must be a power of two, at least 2
  localparam int Q_DEPTH = 4;
  localparam int Q_PW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  verdict;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [10:0] payload_length;
    logic [63:0] source_addr_high;
    logic [63:0] source_addr_low;
    logic        run_last;
  } entry_t;

  // Up to two results per input transaction, in delivery order
  typedef struct packed {
    logic [1:0] num;
    entry_t     e0;
    entry_t     e1;
  } push_t;

  // Link-local fe80::/64 with EUI-64 interface id from the MAC
  function automatic logic [7:0] ll_byte(input logic [47:0] mac, input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'hfe;
      4'd1:    b = 8'h80;
      4'd8:    b = mac[47:40] ^ 8'h02;
      4'd9:    b = mac[39:32];
      4'd10:   b = mac[31:24];
      4'd11:   b = 8'hff;
      4'd12:   b = 8'hfe;
      4'd13:   b = mac[23:16];
      4'd14:   b = mac[15:8];
      4'd15:   b = mac[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] grp_byte(input logic [127:0] addr, input logic [3:0] idx);
    logic [3:0] rev;
    rev = 4'd15 - idx;
    return addr[{rev, 3'b000} +: 8];
  endfunction

endpackage

// ===== sv/iurf_parser.sv =====
// Per-byte header parser and filter: frame state, checks, capture and results.
// Depends on iurf_pkg.
module iurf_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_acc,
  input  logic [7:0]       frame_byte,
  input  logic             end_of_frame,
  input  logic [47:0]      local_mac,
  input  logic [63:0]      group_addr_high,
  input  logic [63:0]      group_addr_low,
  output iurf_pkg::push_t  push
);
  import iurf_pkg::*;

  logic [BC_W-1:0] byte_count_r, byte_count_nxt;
  logic [2:0]      fail_r, fail_nxt;
  logic            gm_r, gm_nxt;
  logic            lm_r, lm_nxt;
  logic [63:0]     src_hi_r, src_hi_nxt;
  logic [63:0]     src_lo_r, src_lo_nxt;
  logic [15:0]     sport_r, sport_nxt;
  logic [15:0]     dport_r, dport_nxt;
  logic [15:0]     ulen_r, ulen_nxt;

  // values after this byte, before the end-of-frame clear
  logic [BC_W-1:0] stp_bc;
  logic [2:0]      stp_fail;
  logic            stp_gm, stp_lm;
  logic [63:0]     stp_src_hi, stp_src_lo;
  logic [15:0]     stp_sport, stp_dport, stp_ulen;

  logic [BC_W-1:0] p;
  logic            live;
  logic [BC_W-1:0] dst_off;
  logic [3:0]      dst_idx;
  logic            emit_payload;
  logic            len_bad;
  logic [2:0]      verd;
  entry_t          pay_e, verd_e;

  assign p       = byte_count_r;
  assign live    = (p < BC_W'(MAX_FRAME_BYTES));
  assign dst_off = p - BC_W'(OFF_DST);
  assign dst_idx = dst_off[3:0];

  always_comb begin
    stp_bc     = byte_count_r;
    stp_fail   = fail_r;
    stp_gm     = gm_r;
    stp_lm     = lm_r;
    stp_src_hi = src_hi_r;
    stp_src_lo = src_lo_r;
    stp_sport  = sport_r;
    stp_dport  = dport_r;
    stp_ulen   = ulen_r;
    if (live) begin
      if (fail_r == VERD_OK) begin
        if ((p == BC_W'(OFF_ETYPE_HI) && frame_byte != ETYPE_HI) ||
            (p == BC_W'(OFF_ETYPE_LO) && frame_byte != ETYPE_LO)) begin
          stp_fail = VERD_ETYPE;
        end else if (p == BC_W'(OFF_VERSION) && frame_byte[7:4] != IP_VER6) begin
          stp_fail = VERD_VERSION;
        end else if (p == BC_W'(OFF_NEXT_HDR) && frame_byte != PROTO_UDP) begin
          stp_fail = VERD_NOT_UDP;
        end
      end
      if (p >= BC_W'(OFF_SRC) && p < BC_W'(OFF_SRC_LO)) begin
        stp_src_hi = {src_hi_r[55:0], frame_byte};
      end
      if (p >= BC_W'(OFF_SRC_LO) && p < BC_W'(OFF_DST)) begin
        stp_src_lo = {src_lo_r[55:0], frame_byte};
      end
      if (p >= BC_W'(OFF_DST) && p < BC_W'(IP_HDR_END)) begin
        if (frame_byte != grp_byte({group_addr_high, group_addr_low}, dst_idx)) begin
          stp_gm = 1'b0;
        end
        if (frame_byte != ll_byte(local_mac, dst_idx)) begin
          stp_lm = 1'b0;
        end
      end
      if (p == BC_W'(OFF_SPORT) || p == BC_W'(OFF_SPORT + 1)) begin
        stp_sport = {sport_r[7:0], frame_byte};
      end
      if (p == BC_W'(OFF_DPORT) || p == BC_W'(OFF_DPORT + 1)) begin
        stp_dport = {dport_r[7:0], frame_byte};
      end
      if (p == BC_W'(OFF_ULEN) || p == BC_W'(OFF_ULEN + 1)) begin
        stp_ulen = {ulen_r[7:0], frame_byte};
      end
      stp_bc = p + BC_W'(1);
    end
  end

  // payload offset p-62 below ulen-8, i.e. p < ulen+54
  assign emit_payload = live && (p >= BC_W'(HDR_BYTES)) && (fail_r == VERD_OK) &&
                        (gm_r || lm_r) && (ulen_r >= 16'(UDP_HDR_BYTES)) &&
                        (17'(p) < 17'(ulen_r) + 17'(HDR_BYTES - UDP_HDR_BYTES));

  assign len_bad = (stp_ulen < 16'(UDP_HDR_BYTES)) ||
                   (17'(stp_ulen) + 17'(IP_HDR_END) > 17'(stp_bc));

  always_comb begin
    if (stp_bc < BC_W'(HDR_BYTES)) begin
      verd = VERD_SHORT;
    end else if (stp_fail != VERD_OK) begin
      verd = stp_fail;
    end else if (!(stp_gm || stp_lm)) begin
      verd = VERD_ADDR;
    end else if (len_bad) begin
      verd = VERD_LENGTH;
    end else begin
      verd = VERD_OK;
    end
  end

  always_comb begin
    pay_e              = '0;
    pay_e.item_kind    = KIND_PAYLOAD;
    pay_e.payload_byte = frame_byte;

    verd_e                  = '0;
    verd_e.item_kind        = KIND_VERDICT;
    verd_e.verdict          = verd;
    verd_e.source_port      = stp_sport;
    verd_e.dest_port        = stp_dport;
    verd_e.payload_length   = (verd == VERD_OK) ?
                              11'(stp_ulen - 16'(UDP_HDR_BYTES)) : 11'd0;
    verd_e.source_addr_high = stp_src_hi;
    verd_e.source_addr_low  = stp_src_lo;
    verd_e.run_last         = 1'b1;

    push = '0;
    if (in_acc) begin
      if (emit_payload) begin
        push.e0 = pay_e;
        push.e1 = verd_e;
        push.num = end_of_frame ? 2'd2 : 2'd1;
      end else if (end_of_frame) begin
        push.e0 = verd_e;
        push.num = 2'd1;
      end
    end
  end

  always_comb begin
    if (in_acc && end_of_frame) begin
      byte_count_nxt = '0;
      fail_nxt       = VERD_OK;
      gm_nxt         = 1'b1;
      lm_nxt         = 1'b1;
      src_hi_nxt     = '0;
      src_lo_nxt     = '0;
      sport_nxt      = '0;
      dport_nxt      = '0;
      ulen_nxt       = '0;
    end else if (in_acc) begin
      byte_count_nxt = stp_bc;
      fail_nxt       = stp_fail;
      gm_nxt         = stp_gm;
      lm_nxt         = stp_lm;
      src_hi_nxt     = stp_src_hi;
      src_lo_nxt     = stp_src_lo;
      sport_nxt      = stp_sport;
      dport_nxt      = stp_dport;
      ulen_nxt       = stp_ulen;
    end else begin
      byte_count_nxt = byte_count_r;
      fail_nxt       = fail_r;
      gm_nxt         = gm_r;
      lm_nxt         = lm_r;
      src_hi_nxt     = src_hi_r;
      src_lo_nxt     = src_lo_r;
      sport_nxt      = sport_r;
      dport_nxt      = dport_r;
      ulen_nxt       = ulen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      fail_r       <= VERD_OK;
      gm_r         <= 1'b1;
      lm_r         <= 1'b1;
      src_hi_r     <= '0;
      src_lo_r     <= '0;
      sport_r      <= '0;
      dport_r      <= '0;
      ulen_r       <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      fail_r       <= fail_nxt;
      gm_r         <= gm_nxt;
      lm_r         <= lm_nxt;
      src_hi_r     <= src_hi_nxt;
      src_lo_r     <= src_lo_nxt;
      sport_r      <= sport_nxt;
      dport_r      <= dport_nxt;
      ulen_r       <= ulen_nxt;
    end
  end

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= BC_W'(MAX_FRAME_BYTES))
    else $error("byte counter beyond saturation point");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && end_of_frame |=> byte_count_r == '0 && fail_r == VERD_OK && gm_r && lm_r)
    else $error("frame state not cleared after verdict");

  a_two_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.num == 2'd2 |-> push.e0.item_kind == KIND_PAYLOAD &&
                         push.e1.item_kind == KIND_VERDICT)
    else $error("two results not payload then verdict");

endmodule

// ===== sv/iurf_out_queue.sv =====
// Small result queue: takes up to two entries per cycle, delivers one.
// Depends on iurf_pkg.
module iurf_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  iurf_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output iurf_pkg::entry_t  head
);
  import iurf_pkg::*;

  entry_t          entries_r [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic            pop;
  logic [Q_PW-1:0] wr_ptr_p1;

  assign out_valid = (count_r != '0);
  assign head      = entries_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // room for the worst case of two results from one transaction
  assign room      = (count_r <= Q_CW'(Q_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + Q_PW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PW'(push.num);
    rd_ptr_nxt = pop ? rd_ptr_r + Q_PW'(1) : rd_ptr_r;
    count_nxt  = count_r + Q_CW'(push.num) - Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      entries_r[wr_ptr_r] <= push.e0;
    end
    if (push.num == 2'd2) begin
      entries_r[wr_ptr_p1] <= push.e1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.num != 2'd0 |-> (Q_CW + 1)'(count_r) + (Q_CW + 1)'(push.num) <= (Q_CW + 1)'(Q_DEPTH))
    else $error("result queue overflow");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("queue count out of range");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && head.item_kind == KIND_PAYLOAD |->
      !head.run_last && head.verdict == VERD_OK && head.source_port == '0)
    else $error("payload item carries verdict fields");

endmodule

// ===== sv/ipv6_udp_receive_filter.sv =====
// Top level of the IPv6/UDP receive filter: config registers, parser, result queue.
// Depends on iurf_pkg, iurf_parser, iurf_out_queue.
//
// Takes a raw Ethernet frame one byte per transaction and accepts a byte every clock
// cycle while in_stall is low; each byte is parsed in the cycle it is accepted and
// its results land in a four-entry result queue; with an empty queue the first result
// is visible in the cycle after acceptance. Most bytes give zero or one result; the
// last byte of a frame can give a payload byte plus the verdict. in_stall rises only
// while the queue could not take two more results. With an unstalled sink the input
// never stalls: the 62 header bytes of a frame give no results and drain the extra
// entry of a two-result frame end long before the next one. A frame passes when it
// is at least 62 bytes, has ethertype 0x86dd, IPv6 version and UDP next header, its
// destination is the configured group or the MAC-derived link-local address, and
// its UDP length fits the frame. Payload bytes stream while all checks so far pass;
// a later bad-length verdict means the streamed payload should be discarded. The UDP
// checksum is not checked. Write the cfg_ registers only while the block is idle.
module ipv6_udp_receive_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_end_of_frame,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_item_kind,
  output logic [7:0]  out_payload_byte,
  output logic [2:0]  out_verdict,
  output logic [15:0] out_source_port,
  output logic [15:0] out_dest_port,
  output logic [10:0] out_payload_length,
  output logic [63:0] out_source_addr_high,
  output logic [63:0] out_source_addr_low,
  output logic        out_run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import iurf_pkg::*;

  logic [47:0] local_mac_r, local_mac_nxt;
  logic [63:0] group_hi_r, group_hi_nxt;
  logic [63:0] group_lo_r, group_lo_nxt;
  logic        cfg_wr;
  logic        room;
  logic        in_acc;
  push_t       push;
  entry_t      head;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    local_mac_nxt = local_mac_r;
    group_hi_nxt  = group_hi_r;
    group_lo_nxt  = group_lo_r;
    if (cfg_wr) begin
      case (cfg_index)
        CFG_LOCAL_MAC: local_mac_nxt = cfg_data[47:0];
        CFG_GROUP_HI:  group_hi_nxt  = cfg_data;
        CFG_GROUP_LO:  group_lo_nxt  = cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_mac_r <= MAC_RST;
      group_hi_r  <= GROUP_HI_RST;
      group_lo_r  <= GROUP_LO_RST;
    end else begin
      local_mac_r <= local_mac_nxt;
      group_hi_r  <= group_hi_nxt;
      group_lo_r  <= group_lo_nxt;
    end
  end

  assign in_stall = !room;
  assign in_acc   = in_valid && !in_stall;

  iurf_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_acc          (in_acc),
    .frame_byte      (in_frame_byte),
    .end_of_frame    (in_end_of_frame),
    .local_mac       (local_mac_r),
    .group_addr_high (group_hi_r),
    .group_addr_low  (group_lo_r),
    .push            (push)
  );

  iurf_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_item_kind        = head.item_kind;
  assign out_payload_byte     = head.payload_byte;
  assign out_verdict          = head.verdict;
  assign out_source_port      = head.source_port;
  assign out_dest_port        = head.dest_port;
  assign out_payload_length   = head.payload_length;
  assign out_source_addr_high = head.source_addr_high;
  assign out_source_addr_low  = head.source_addr_low;
  assign out_run_last         = head.run_last;

endmodule
